@@ hdl/altm_pkg.sv @@
// Shared types and fixed field widths for the track mixer looper.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package altm_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int MUTE_W       = 8;
	localparam int REQ_W        = 3;
	localparam int COUNT_OUT_W  = 4;
	localparam int BLOCKS_OUT_W = 5;

	typedef enum logic [REQ_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_RECORD  = 3'd1,
		CMD_PLAY    = 3'd2,
		CMD_OVERDUB = 3'd3,
		CMD_RESTART = 3'd4,
		CMD_CLEAR   = 3'd5,
		CMD_LAYER   = 3'd6,
		CMD_REMOVE  = 3'd7
	} cmd_t;

endpackage

`default_nettype wire

@@ hdl/altm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module altm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/audio_looper_track_mixer_core.sv @@
// Looper top level: command sequencer, track slot map and loop state.
// Depends on altm_pkg and altm_ram (sample store).
// Play and overdub issue one store read per held track on the single read port, then
// wait for the registered read data and saturate the sum; clear and layer make one
// store write per sample to zero a track; every other command finishes in the execute
// state. One command at a time; busy is low in the done cycle, so a new command can
// start in the done cycle. Results cannot be held off.
// Reset (arst_n low) is asynchronous: one track of one block, position 0, all unmuted.
// The sample store is not cleared at reset; the first track reads undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module audio_looper_track_mixer_core #(
	parameter int MAX_TRACKS    = 8,
	parameter int MAX_BLOCKS    = 16,
	parameter int BLOCK_SAMPLES = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [altm_pkg::MUTE_W-1:0]            cfg_wdata,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [altm_pkg::REQ_W-1:0]             req_type,
	input  wire logic signed [altm_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                        done,
	output logic signed [altm_pkg::SAMPLE_W-1:0]        sample_out,
	output logic                                        clipped,
	output logic                                        store_full,
	output logic [altm_pkg::COUNT_OUT_W-1:0]            tracks_in_use,
	output logic [altm_pkg::BLOCKS_OUT_W-1:0]           loop_blocks_out
);

	localparam int SPAN = MAX_BLOCKS * BLOCK_SAMPLES;
	localparam int PW   = $clog2(SPAN);
	localparam int LW   = $clog2(SPAN + 1);
	localparam int BW   = $clog2(MAX_BLOCKS + 1);
	localparam int TW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW   = $clog2(MAX_TRACKS + 1);
	localparam int MD   = 1 << TW;
	localparam int SW   = altm_pkg::SAMPLE_W + 1 + TW;
	localparam int RAM_D = MAX_TRACKS * (1 << PW);
	localparam int AW   = (RAM_D > 1) ? $clog2(RAM_D) : 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MIX,
		S_SAT,
		S_ZERO
	} state_t;

	state_t                         state_q;
	altm_pkg::cmd_t                 req_q;
	logic [altm_pkg::SAMPLE_W-1:0]  smp_q;
	logic [altm_pkg::MUTE_W-1:0]    mute_q;
	logic [PW-1:0]                  pos_q;
	logic [LW-1:0]                  len_q;
	logic [BW-1:0]                  blocks_q;
	logic [CW-1:0]                  count_q;
	logic [TW-1:0]                  active_q;
	logic [TW-1:0]                  map_q [MD];
	logic [CW-1:0]                  t_q;
	logic [TW-1:0]                  zslot_q;
	logic [PW-1:0]                  zpos_q;
	logic signed [SW-1:0]           sum_q;
	logic                           rd_vld_s1;
	logic                           keep_s1;
	logic                           done_q;
	logic signed [altm_pkg::SAMPLE_W-1:0] sample_q;
	logic                           clip_q;
	logic                           full_q;

	logic [TW-1:0]                  map_idx;
	logic [TW-1:0]                  map_rd;
	logic [LW-1:0]                  nxt;
	logic                           at_end;
	logic [CW-1:0]                  cnt_m1;
	logic [MD-1:0]                  keep_v;
	logic                           issue;
	logic                           rec_ok;
	logic signed [altm_pkg::SAMPLE_W-1:0] sat_val;
	logic                           sat_clip;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [altm_pkg::SAMPLE_W-1:0]  ram_wdata;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [altm_pkg::SAMPLE_W-1:0]  ram_rdata;

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign sample_out      = sample_q;
	assign clipped         = clip_q;
	assign store_full      = full_q;
	assign tracks_in_use   = altm_pkg::COUNT_OUT_W'(count_q);
	assign loop_blocks_out = altm_pkg::BLOCKS_OUT_W'(blocks_q);

	// Tracks past the mute register width are never muted.
	for (genvar i = 0; i < MD; i++) begin : g_keep
		if (i < altm_pkg::MUTE_W) begin : g_bit
			assign keep_v[i] = ~mute_q[i];
		end else begin : g_none
			assign keep_v[i] = 1'b1;
		end
	end

	assign nxt    = LW'(pos_q) + LW'(1);
	assign at_end = (nxt >= len_q);
	assign cnt_m1 = count_q - CW'(1);
	assign issue  = (state_q == S_MIX) && (t_q < count_q);
	assign rec_ok = (count_q != '0) && (!at_end || (blocks_q < BW'(MAX_BLOCKS)));

	// Logical track to physical slot; one read per cycle.
	always_comb begin
		map_idx = active_q;
		case (state_q)
			S_MIX: map_idx = t_q[TW-1:0];
			S_EXEC: begin
				if (req_q == altm_pkg::CMD_LAYER) begin
					map_idx = count_q[TW-1:0];
				end else if (req_q == altm_pkg::CMD_CLEAR) begin
					map_idx = '0;
				end
			end
			default: map_idx = active_q;
		endcase
	end

	assign map_rd = map_q[map_idx];

	always_comb begin
		sat_val  = sum_q[altm_pkg::SAMPLE_W-1:0];
		sat_clip = 1'b0;
		if (sum_q > SAT_HI) begin
			sat_val  = altm_pkg::SAMPLE_W'(32767);
			sat_clip = 1'b1;
		end else if (sum_q < SAT_LO) begin
			sat_val  = altm_pkg::SAMPLE_W'(-32768);
			sat_clip = 1'b1;
		end
	end

	// Store port control: reads only in the mix pass, writes never overlap them.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'({map_rd, pos_q});
		ram_wdata = smp_q;
		ram_re    = issue;
		ram_raddr = AW'({map_rd, pos_q});
		case (state_q)
			S_EXEC: begin
				if (req_q == altm_pkg::CMD_RECORD && rec_ok) begin
					ram_we    = 1'b1;
					ram_waddr = AW'({map_rd, nxt[PW-1:0]});
				end
			end
			S_SAT: begin
				ram_we = (req_q == altm_pkg::CMD_OVERDUB) && (count_q != '0);
			end
			S_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = AW'({zslot_q, zpos_q});
				ram_wdata = '0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= '0;
		end else if (cfg_we) begin
			mute_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= altm_pkg::CMD_TICK;
			pos_q     <= '0;
			len_q     <= LW'(BLOCK_SAMPLES);
			blocks_q  <= BW'(1);
			count_q   <= CW'(1);
			active_q  <= '0;
			for (int i = 0; i < MD; i++) begin
				map_q[i] <= TW'(i);
			end
			t_q       <= '0;
			zslot_q   <= '0;
			zpos_q    <= '0;
			sum_q     <= '0;
			rd_vld_s1 <= 1'b0;
			keep_s1   <= 1'b0;
			done_q    <= 1'b0;
			sample_q  <= '0;
			clip_q    <= 1'b0;
			full_q    <= 1'b0;
			smp_q     <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			keep_s1   <= keep_v[t_q[TW-1:0]];
			if (rd_vld_s1 && keep_s1) begin
				sum_q <= sum_q + SW'($signed(ram_rdata));
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= altm_pkg::cmd_t'(req_type);
						smp_q   <= sample_in;
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					sample_q <= '0;
					clip_q   <= 1'b0;
					full_q   <= 1'b0;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
					case (req_q)
						altm_pkg::CMD_RECORD: begin
							if (count_q != '0) begin
								if (rec_ok) begin
									if (at_end) begin
										blocks_q <= blocks_q + BW'(1);
										len_q    <= len_q + LW'(BLOCK_SAMPLES);
									end
									pos_q <= nxt[PW-1:0];
								end else begin
									full_q <= 1'b1;
								end
							end
						end
						altm_pkg::CMD_PLAY, altm_pkg::CMD_OVERDUB: begin
							pos_q   <= at_end ? '0 : nxt[PW-1:0];
							t_q     <= '0;
							sum_q   <= '0;
							done_q  <= 1'b0;
							state_q <= S_MIX;
						end
						altm_pkg::CMD_RESTART: begin
							pos_q <= '0;
						end
						altm_pkg::CMD_CLEAR: begin
							count_q  <= CW'(1);
							active_q <= '0;
							blocks_q <= BW'(1);
							len_q    <= LW'(BLOCK_SAMPLES);
							pos_q    <= '0;
							zslot_q  <= map_rd;
							zpos_q   <= '0;
							done_q   <= 1'b0;
							state_q  <= S_ZERO;
						end
						altm_pkg::CMD_LAYER: begin
							if (count_q >= CW'(MAX_TRACKS)) begin
								full_q <= 1'b1;
							end else begin
								zslot_q  <= map_rd;
								zpos_q   <= '0;
								active_q <= count_q[TW-1:0];
								count_q  <= count_q + CW'(1);
								done_q   <= 1'b0;
								state_q  <= S_ZERO;
							end
						end
						altm_pkg::CMD_REMOVE: begin
							if (count_q != '0) begin
								// Close the gap and park the freed slot at the old top.
								for (int i = 0; i < MD - 1; i++) begin
									if (i >= int'(active_q) && i + 1 < int'(count_q)) begin
										map_q[i] <= map_q[i + 1];
									end
								end
								map_q[cnt_m1[TW-1:0]] <= map_rd;
								count_q <= cnt_m1;
								if (active_q != '0) begin
									active_q <= active_q - TW'(1);
								end
							end
						end
						default: begin
							pos_q <= pos_q;
						end
					endcase
				end

				S_MIX: begin
					if (issue) begin
						t_q <= t_q + CW'(1);
					end else if (!rd_vld_s1) begin
						state_q <= S_SAT;
					end
				end

				S_SAT: begin
					sample_q <= sat_val;
					clip_q   <= sat_clip;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end

				S_ZERO: begin
					zpos_q <= zpos_q + PW'(1);
					if (zpos_q == PW'(SPAN - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	altm_ram #(
		.WIDTH(altm_pkg::SAMPLE_W),
		.DEPTH(RAM_D)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a command in flight");

	a_pos_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(pos_q) < len_q)
		else $error("loop position past loop end");

	a_active_held: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (CW'(active_q) < count_q))
		else $error("active track not among held tracks");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we))
		else $error("store read and write in the same cycle");

endmodule

`default_nettype wire

@@ tb/looper_mix_checker.sv @@
// Checker for the track mixer looper: tracks accepted commands and mute writes,
// predicts each result word and compares it with the done strobe outputs.
// Depends on altm_pkg for the command codes and field widths.
`timescale 1ns / 1ps

module looper_mix_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [altm_pkg::MUTE_W-1:0]          cfg_wdata,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [altm_pkg::REQ_W-1:0]           req_type,
	input  logic signed [altm_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 done,
	input  logic signed [altm_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 clipped,
	input  logic                                 store_full,
	input  logic [altm_pkg::COUNT_OUT_W-1:0]     tracks_in_use,
	input  logic [altm_pkg::BLOCKS_OUT_W-1:0]    loop_blocks_out,
	output int                                   error_count,
	output int                                   words_waiting
);
	import altm_pkg::*;

	localparam int unsigned NUM_TRACKS = 8;
	localparam int unsigned NUM_BLOCKS = 16;
	localparam int unsigned BLOCK_LEN  = 256;
	localparam int unsigned SPAN       = NUM_BLOCKS * BLOCK_LEN;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  mix;
		logic                        clip;
		logic                        full;
		logic [COUNT_OUT_W-1:0]      tracks;
		logic [BLOCKS_OUT_W-1:0]     blocks;
	} mix_word_t;

	logic [SAMPLE_W-1:0] track_mem [NUM_TRACKS*SPAN];
	int unsigned         play_pos;
	int unsigned         loop_blks;
	int unsigned         held;
	int unsigned         active;
	logic [MUTE_W-1:0]   mute;
	mix_word_t           mix_words_q [$];

	function automatic int unsigned mem_addr(input int unsigned trk, input int unsigned p);
		return (trk % NUM_TRACKS) * SPAN + (p % SPAN);
	endfunction

	task automatic wipe_track(input int unsigned trk);
		for (int unsigned i = 0; i < SPAN; i++)
			track_mem[mem_addr(trk, i)] = '0;
	endtask

	// Advance with wrap, then sum every unmuted track at the new position.
	task automatic mix_next(output logic signed [SAMPLE_W-1:0] mix, output logic clip);
		int                         sum;
		int unsigned                nxt;
		logic signed [SAMPLE_W-1:0] v;
		nxt = play_pos + 1;
		if (nxt >= loop_blks * BLOCK_LEN)
			nxt = 0;
		play_pos = nxt;
		sum = 0;
		for (int unsigned t = 0; t < held && t < NUM_TRACKS; t++) begin
			if (t < MUTE_W && mute[t])
				continue;
			v = track_mem[mem_addr(t, play_pos)];
			sum += v;
		end
		clip = 1'b0;
		if (sum > 32767) begin
			sum = 32767;
			clip = 1'b1;
		end
		if (sum < -32768) begin
			sum = -32768;
			clip = 1'b1;
		end
		mix = sum[SAMPLE_W-1:0];
	endtask

	task automatic advance_looper(input cmd_t cmd, input logic [SAMPLE_W-1:0] smp,
			output mix_word_t res);
		int unsigned                nxt;
		int unsigned                n_move;
		logic signed [SAMPLE_W-1:0] m;
		logic                       c;
		res = '0;
		m = '0;
		c = 1'b0;
		// Clamp a position left past the loop end.
		if (play_pos >= loop_blks * BLOCK_LEN)
			play_pos = loop_blks * BLOCK_LEN - 1;
		case (cmd)
			CMD_RECORD: begin
				if (held != 0) begin
					nxt = play_pos + 1;
					if (nxt >= loop_blks * BLOCK_LEN && loop_blks >= NUM_BLOCKS) begin
						res.full = 1'b1;
					end else begin
						if (nxt >= loop_blks * BLOCK_LEN)
							loop_blks++;
						play_pos = nxt;
						track_mem[mem_addr(active, play_pos)] = smp;
					end
				end
			end
			CMD_PLAY: begin
				mix_next(m, c);
			end
			CMD_OVERDUB: begin
				mix_next(m, c);
				if (held != 0)
					track_mem[mem_addr(active, play_pos)] = smp;
			end
			CMD_RESTART: begin
				play_pos = 0;
			end
			CMD_CLEAR: begin
				wipe_track(0);
				held = 1;
				active = 0;
				loop_blks = 1;
				play_pos = 0;
			end
			CMD_LAYER: begin
				if (held >= NUM_TRACKS) begin
					res.full = 1'b1;
				end else begin
					wipe_track(held);
					active = held;
					held++;
				end
			end
			CMD_REMOVE: begin
				if (held != 0) begin
					// Shift the tracks above the active one down by one.
					if (active + 1 < held) begin
						n_move = (held - 1 - active) * SPAN;
						for (int unsigned i = 0; i < n_move; i++)
							track_mem[active*SPAN + i] = track_mem[(active+1)*SPAN + i];
					end
					held--;
					if (active > 0)
						active--;
				end
			end
			default: ;
		endcase
		res.mix = m;
		res.clip = c;
		res.tracks = held[COUNT_OUT_W-1:0];
		res.blocks = loop_blks[BLOCKS_OUT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		mix_word_t got;
		mix_word_t want;
		if (!arst_n) begin
			play_pos = 0;
			loop_blks = 1;
			held = 1;
			active = 0;
			mute = '0;
			mix_words_q.delete();
			error_count = 0;
			words_waiting = 0;
		end else begin
			if (done) begin
				if (mix_words_q.size() == 0) begin
					$error("unexpected result word: sample_out %0d", sample_out);
					error_count++;
				end else begin
					want = mix_words_q.pop_front();
					if (sample_out !== want.mix) begin
						$error("sample_out: expected %0d, actual %0d", want.mix, sample_out);
						error_count++;
					end
					if (clipped !== want.clip) begin
						$error("clipped: expected %0d, actual %0d", want.clip, clipped);
						error_count++;
					end
					if (store_full !== want.full) begin
						$error("store_full: expected %0d, actual %0d", want.full, store_full);
						error_count++;
					end
					if (tracks_in_use !== want.tracks) begin
						$error("tracks_in_use: expected %0d, actual %0d", want.tracks,
							tracks_in_use);
						error_count++;
					end
					if (loop_blocks_out !== want.blocks) begin
						$error("loop_blocks_out: expected %0d, actual %0d", want.blocks,
							loop_blocks_out);
						error_count++;
					end
				end
			end
			if (cfg_we)
				mute = cfg_wdata;
			if (start && !busy) begin
				advance_looper(cmd_t'(req_type), sample_in, got);
				mix_words_q.push_back(got);
			end
			words_waiting = mix_words_q.size();
		end
	end

endmodule

@@ tb/audio_looper_track_mixer_core_test.sv @@
// Top of the looper test: clock, reset, command stimulus in bursts and mute writes.
// Depends on altm_pkg, audio_looper_track_mixer_core and looper_mix_checker.
`timescale 1ns / 1ps

module audio_looper_track_mixer_core_test;
	import altm_pkg::*;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [MUTE_W-1:0]            cfg_wdata = '0;
	logic                         start = 1'b0;
	logic [REQ_W-1:0]             req_type = CMD_TICK;
	logic signed [SAMPLE_W-1:0]   sample_in = '0;
	logic                         busy;
	logic                         done;
	logic signed [SAMPLE_W-1:0]   sample_out;
	logic                         clipped;
	logic                         store_full;
	logic [COUNT_OUT_W-1:0]       tracks_in_use;
	logic [BLOCKS_OUT_W-1:0]      loop_blocks_out;
	int                           fail_count;
	int                           words_waiting;
	int                           words_sent = 0;
	int                           burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	audio_looper_track_mixer_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.sample_in       (sample_in),
		.done            (done),
		.sample_out      (sample_out),
		.clipped         (clipped),
		.store_full      (store_full),
		.tracks_in_use   (tracks_in_use),
		.loop_blocks_out (loop_blocks_out)
	);

	looper_mix_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.sample_in       (sample_in),
		.done            (done),
		.sample_out      (sample_out),
		.clipped         (clipped),
		.store_full      (store_full),
		.tracks_in_use   (tracks_in_use),
		.loop_blocks_out (loop_blocks_out),
		.error_count     (fail_count),
		.words_waiting   (words_waiting)
	);

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [MUTE_W-1:0] pick_mute();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 8'(1 << $urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	// Called at a rising edge; returns after the taking edge and any burst gap.
	task automatic issue(input cmd_t cmd, input logic [SAMPLE_W-1:0] smp);
		logic taken;
		start <= 1'b1;
		req_type <= cmd;
		sample_in <= smp;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 8);
		end
	endtask

	// Hold off commands until every word is back, then write the mask.
	task automatic write_mute(input logic [MUTE_W-1:0] value);
		start <= 1'b0;
		do @(negedge clk); while (words_waiting != 0 || busy);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mute(8'h00);

		// Clear first so track 0 is defined before anything plays it.
		issue(CMD_CLEAR, 16'h0000);
		issue(CMD_PLAY, 16'h7FFF);
		issue(CMD_RESTART, 16'h8000);
		issue(CMD_RECORD, 16'h7FFF);
		issue(CMD_RECORD, 16'h8000);
		issue(CMD_RECORD, 16'h0001);
		issue(CMD_RESTART, 16'h0000);
		issue(CMD_LAYER, 16'h0000);
		issue(CMD_OVERDUB, 16'h7FFF);
		issue(CMD_OVERDUB, 16'h8000);
		issue(CMD_RESTART, 16'h0000);
		issue(CMD_PLAY, 16'h0000);
		issue(CMD_PLAY, 16'h0000);
		issue(CMD_TICK, 16'hFFFF);
		issue(CMD_REMOVE, 16'h0000);
		issue(CMD_REMOVE, 16'h0000);
		// No tracks held
		issue(CMD_PLAY, 16'h1234);
		issue(CMD_OVERDUB, 16'h1234);
		issue(CMD_RECORD, 16'h4321);
		issue(CMD_REMOVE, 16'h0000);
		issue(CMD_LAYER, 16'h0000);
		issue(CMD_PLAY, 16'h0000);

		write_mute(8'hFF);
		issue(CMD_PLAY, 16'h0000);
		issue(CMD_OVERDUB, 16'h5555);
		write_mute(8'h00);

		// Wrap a one-block loop, grow it by a block, then fill every track.
		issue(CMD_CLEAR, 16'h0000);
		repeat (270) issue(CMD_PLAY, rand_sample());
		repeat (260) issue(CMD_RECORD, rand_sample());
		repeat (8) issue(CMD_LAYER, rand_sample());
		repeat (60) issue($urandom_range(0, 1) ? CMD_OVERDUB : CMD_PLAY, rand_sample());
		repeat (3) issue(CMD_REMOVE, 16'h0000);
		repeat (40) issue(CMD_PLAY, rand_sample());

		target = 1180;
		while (words_sent < target) begin
			if ($urandom_range(0, 1))
				write_mute(pick_mute());
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if ($urandom_range(0, 1))
						issue(CMD_RESTART, rand_sample());
					repeat ($urandom_range(1, 150)) issue(CMD_RECORD, rand_sample());
				end
				3, 4: begin
					repeat ($urandom_range(1, 150)) issue(CMD_PLAY, rand_sample());
				end
				5, 6: begin
					repeat ($urandom_range(1, 100))
						issue($urandom_range(0, 2) ? CMD_OVERDUB : CMD_PLAY, rand_sample());
				end
				7: begin
					repeat ($urandom_range(1, 4))
						issue($urandom_range(0, 1) ? CMD_LAYER : CMD_REMOVE, rand_sample());
				end
				8: begin
					repeat ($urandom_range(1, 12))
						issue(cmd_t'(3'($urandom_range(0, 7))), rand_sample());
				end
				default: begin
					issue(CMD_CLEAR, rand_sample());
					repeat ($urandom_range(0, 3)) issue(CMD_LAYER, rand_sample());
				end
			endcase
		end
		write_mute(8'hFF);
		repeat (20) issue($urandom_range(0, 1) ? CMD_OVERDUB : CMD_PLAY, rand_sample());

		start <= 1'b0;
		do @(negedge clk); while (words_waiting != 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && words_waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#500_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
